### rtl/sobvg_pkg.sv
// sobvg_pkg: shared types and constants for the vertical sobel gradient core
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package sobvg_pkg;

  // line buffer geometry
  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int PCNT_W    = $clog2(MAX_WIDTH + 2);

  // configuration register widths
  localparam int W_REG_W    = 11;
  localparam int H_REG_W    = 13;
  localparam int ROW_IN_W   = H_REG_W + 1;
  localparam int ROW_OUT_W  = H_REG_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [W_REG_W-1:0] WIDTH_RESET  = W_REG_W'(640);
  localparam logic [H_REG_W-1:0] HEIGHT_RESET = H_REG_W'(480);
  localparam logic [W_REG_W-1:0] MAX_W_EFF    = W_REG_W'(MAX_WIDTH);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);

  // item kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // output queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int CREDIT_W   = $clog2(FIFO_DEPTH + 3);

  // one rgb pixel, red in the low byte
  typedef logic [23:0] pixel_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_end;
  } res_out_t;

  typedef struct packed {
    logic left_ok;
    logic right_ok;
    logic top_ok;
    logic bot_ok;
  } edge_mask_t;

  // issue stage decision for one accepted beat
  typedef struct packed {
    logic             push;
    logic [COL_W-1:0] col;
    pixel_t           px;
    logic             res;
    edge_mask_t       mask;
    logic             last;
  } issue_t;

  // line buffer read stage, one new window column
  typedef struct packed {
    logic       valid;
    pixel_t     px;
    pixel_t     top;
    pixel_t     mid;
    logic       res;
    edge_mask_t mask;
    logic       last;
  } tap_t;

endpackage

### rtl/sobvg_ctrl.sv
// sobvg_ctrl: configuration registers and frame position counters
// depends on sobvg_pkg; decides per beat whether it pushes and whether a result is due
`timescale 1ns / 1ps

module sobvg_ctrl import sobvg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_fire,
  input  pix_in_t               in_beat,
  input  logic                  cfg_fire,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  restart,
  output issue_t                issue
);

  logic [W_REG_W-1:0]   width_r, width_nxt;
  logic [H_REG_W-1:0]   height_r, height_nxt;
  logic [COL_W-1:0]     in_col_r, in_col_nxt;
  logic [ROW_IN_W-1:0]  in_row_r, in_row_nxt;
  logic [COL_W-1:0]     out_col_r, out_col_nxt;
  logic [ROW_OUT_W-1:0] out_row_r, out_row_nxt;
  logic [PCNT_W-1:0]    pcnt_r, pcnt_nxt;

  logic [W_REG_W-1:0] w_eff;
  logic [H_REG_W-1:0] h_eff;
  logic [PCNT_W-1:0]  prime_lim;
  logic               draining;
  logic               in_col_wrap;
  logic               out_col_wrap;

  // effective frame size
  assign w_eff = (width_r == '0) ? W_REG_W'(1) :
                 ((width_r > MAX_W_EFF) ? MAX_W_EFF : width_r);
  assign h_eff = (height_r == '0) ? H_REG_W'(1) : height_r;

  assign prime_lim = PCNT_W'(w_eff) + PCNT_W'(1);
  assign draining  = in_row_r >= ROW_IN_W'(h_eff);

  // issue decision
  always_comb begin
    issue.push = in_fire && !((in_beat.kind == KIND_FLUSH) && !draining);
    issue.col  = in_col_r;
    issue.px   = draining ? '0 : {in_beat.blue_in, in_beat.green_in, in_beat.red_in};
    issue.res  = pcnt_r >= prime_lim;
    issue.mask.left_ok  = out_col_r != '0;
    issue.mask.right_ok = (W_REG_W'(out_col_r) + W_REG_W'(1)) < w_eff;
    issue.mask.top_ok   = out_row_r != '0;
    issue.mask.bot_ok   = (ROW_IN_W'(out_row_r) + ROW_IN_W'(1)) < ROW_IN_W'(h_eff);
    issue.last = !issue.mask.right_ok && !issue.mask.bot_ok;
  end

  assign restart = cfg_fire && ((cfg_index == REG_WIDTH) || (cfg_index == REG_HEIGHT));

  assign in_col_wrap  = (W_REG_W'(in_col_r) + W_REG_W'(1)) >= w_eff;
  assign out_col_wrap = !issue.mask.right_ok;

  // counter update
  always_comb begin
    width_nxt   = width_r;
    height_nxt  = height_r;
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    pcnt_nxt    = pcnt_r;
    if (cfg_fire) begin
      if (cfg_index == REG_WIDTH) begin
        width_nxt = cfg_data[W_REG_W-1:0];
      end
      if (cfg_index == REG_HEIGHT) begin
        height_nxt = cfg_data[H_REG_W-1:0];
      end
      if (restart) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
        pcnt_nxt    = '0;
      end
    end else if (issue.push) begin
      if (in_col_wrap) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + ROW_IN_W'(1);
      end else begin
        in_col_nxt = in_col_r + COL_W'(1);
      end
      if (!issue.res) begin
        pcnt_nxt = pcnt_r + PCNT_W'(1);
      end else if (issue.last) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
        pcnt_nxt    = '0;
      end else if (out_col_wrap) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + ROW_OUT_W'(1);
      end else begin
        out_col_nxt = out_col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= WIDTH_RESET;
      height_r  <= HEIGHT_RESET;
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      pcnt_r    <= '0;
    end else begin
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      pcnt_r    <= pcnt_nxt;
    end
  end

endmodule

### rtl/sobvg_line_buf.sv
// sobvg_line_buf: the two line memories, read-modify-write per column
// depends on sobvg_pkg; forwards the pending write when the same column is read again
`timescale 1ns / 1ps

module sobvg_line_buf import sobvg_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  issue_t issue,
  output tap_t   tap
);

  pixel_t row_above_mem [MAX_WIDTH];
  pixel_t row_two_mem   [MAX_WIDTH];

  pixel_t           above_q_r;
  pixel_t           two_q_r;
  logic             s1_v_r;
  logic [COL_W-1:0] s1_col_r;
  pixel_t           s1_px_r;
  logic             s1_res_r;
  edge_mask_t       s1_mask_r;
  logic             s1_last_r;
  logic             fwd_r;
  pixel_t           fwd_top_r;
  pixel_t           fwd_mid_r;

  pixel_t mid_eff;
  pixel_t top_eff;

  // read data, or the write still in flight to the same column
  assign top_eff = fwd_r ? fwd_top_r : two_q_r;
  assign mid_eff = fwd_r ? fwd_mid_r : above_q_r;

  // row above memory: read on issue, write back the new pixel
  always_ff @(posedge clk) begin
    if (issue.push) begin
      above_q_r <= row_above_mem[issue.col];
    end
    if (s1_v_r) begin
      row_above_mem[s1_col_r] <= s1_px_r;
    end
  end

  // row two above memory: takes the old row above
  always_ff @(posedge clk) begin
    if (issue.push) begin
      two_q_r <= row_two_mem[issue.col];
    end
    if (s1_v_r) begin
      row_two_mem[s1_col_r] <= mid_eff;
    end
  end

  // read stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= issue.push;
    end
  end

  // read stage payload and forwarding capture
  always_ff @(posedge clk) begin
    if (issue.push) begin
      s1_col_r  <= issue.col;
      s1_px_r   <= issue.px;
      s1_res_r  <= issue.res;
      s1_mask_r <= issue.mask;
      s1_last_r <= issue.last;
      fwd_r     <= s1_v_r && (s1_col_r == issue.col);
      fwd_top_r <= mid_eff;
      fwd_mid_r <= s1_px_r;
    end
  end

  always_comb begin
    tap.valid = s1_v_r;
    tap.px    = s1_px_r;
    tap.top   = top_eff;
    tap.mid   = mid_eff;
    tap.res   = s1_res_r;
    tap.mask  = s1_mask_r;
    tap.last  = s1_last_r;
  end

endmodule

### rtl/sobvg_window.sv
// sobvg_window: 3x3 window registers and the per-channel gradient sum
// depends on sobvg_pkg; fed by sobvg_line_buf, writes results into the output queue
`timescale 1ns / 1ps

module sobvg_window import sobvg_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     restart,
  input  tap_t     tap,
  output logic     wr_en,
  output res_out_t wr_data
);

  // win_r[row][col], col 2 is the newest
  pixel_t     win_r [3][3];
  logic       s2_v_r;
  edge_mask_t s2_mask_r;
  logic       s2_last_r;

  // weighted column sum of one channel, clamped to 0..255
  function automatic logic [7:0] grad_chan(
    input logic [7:0] t0, input logic [7:0] t1, input logic [7:0] t2,
    input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
    input edge_mask_t m
  );
    logic [9:0] up;
    logic [9:0] dn;
    logic [9:0] diff;
    logic [7:0] res;
    up = '0;
    dn = '0;
    if (m.top_ok) begin
      up = {1'b0, t1, 1'b0} + (m.left_ok ? 10'(t0) : 10'd0)
         + (m.right_ok ? 10'(t2) : 10'd0);
    end
    if (m.bot_ok) begin
      dn = {1'b0, b1, 1'b0} + (m.left_ok ? 10'(b0) : 10'd0)
         + (m.right_ok ? 10'(b2) : 10'd0);
    end
    diff = dn - up;
    if (dn <= up) begin
      res = 8'd0;
    end else if (diff > 10'd255) begin
      res = 8'd255;
    end else begin
      res = diff[7:0];
    end
    return res;
  endfunction

  // window shift on every pushed column
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else if (tap.valid) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= tap.top;
      win_r[1][2] <= tap.mid;
      win_r[2][2] <= tap.px;
    end
  end

  // sum stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= tap.valid && tap.res;
    end
  end

  always_ff @(posedge clk) begin
    if (tap.valid) begin
      s2_mask_r <= tap.mask;
      s2_last_r <= tap.last;
    end
  end

  // result per channel
  assign wr_en = s2_v_r;
  always_comb begin
    wr_data.red_out   = grad_chan(win_r[0][0][7:0], win_r[0][1][7:0], win_r[0][2][7:0],
                                  win_r[2][0][7:0], win_r[2][1][7:0], win_r[2][2][7:0],
                                  s2_mask_r);
    wr_data.green_out = grad_chan(win_r[0][0][15:8], win_r[0][1][15:8], win_r[0][2][15:8],
                                  win_r[2][0][15:8], win_r[2][1][15:8], win_r[2][2][15:8],
                                  s2_mask_r);
    wr_data.blue_out  = grad_chan(win_r[0][0][23:16], win_r[0][1][23:16], win_r[0][2][23:16],
                                  win_r[2][0][23:16], win_r[2][1][23:16], win_r[2][2][23:16],
                                  s2_mask_r);
    wr_data.frame_end = s2_last_r;
  end

endmodule

### rtl/sobvg_out_fifo.sv
// sobvg_out_fifo: small result queue in front of the output channel
// depends on sobvg_pkg; its fill level feeds the input credit check
`timescale 1ns / 1ps

module sobvg_out_fifo import sobvg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  res_out_t              wr_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output res_out_t              out_data,
  output logic [FIFO_CNT_W-1:0] count
);

  res_out_t              q_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r;
  logic [FIFO_PTR_W-1:0] rd_ptr_r;
  logic [FIFO_CNT_W-1:0] count_r;
  logic                  rd_en;

  assign out_valid = count_r != '0;
  assign out_data  = q_r[rd_ptr_r];
  assign rd_en     = out_valid && !out_stall;
  assign count     = count_r;

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= wr_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + FIFO_CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - FIFO_CNT_W'(1);
      end
    end
  end

endmodule

### rtl/sobvg_core_top.sv
// sobvg_core_top: holds no logic of its own
// the block's top level is sobel_vertical_gradient_rgb_core, built on sobvg_pkg
`timescale 1ns / 1ps

### rtl/sobel_vertical_gradient_rgb_core.sv
// sobel_vertical_gradient_rgb_core: top level of the vertical sobel gradient filter
// depends on sobvg_pkg, sobvg_ctrl, sobvg_line_buf, sobvg_window, sobvg_out_fifo
//
// Usage:
//   in_*  : rgb pixels in raster order, or flush beats (kind = 1) that push a
//           zero pixel once the frame's pixels are all in. A beat moves when
//           in_valid is high and in_stall is low.
//   out_* : one gradient result per pushed pixel once a row plus one pixel of
//           the frame is buffered; frame_end marks the frame's last result.
//   cfg_* : image_width (index 0) and image_height (index 1); a write to either restarts
//           the frame. A waiting write stalls input and lands once the pipeline is empty.
// Throughput: one beat per clock while in_stall is low. The line memories are read
//   on the accept edge and written back in the following cycle, with the pending
//   write forwarded when the same column is read again (a one pixel wide frame).
// Path: a result-carrying beat passes the read stage, the window and sum stage
//   and the output queue before it shows on out_valid.
// Stall: results wait in a four-beat queue; in_stall rises when the queue
//   plus the results still in the pipeline fill it, so no beat is dropped.
// Reset: 640 x 480 frame, counters and window cleared. The line memories are
//   not cleared; unwritten entries only fall outside the image.
`timescale 1ns / 1ps

module sobel_vertical_gradient_rgb_core import sobvg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pix_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output res_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  issue_t                issue;
  tap_t                  tap;
  logic                  restart;
  logic                  in_fire;
  logic                  cfg_fire;
  logic                  wr_en;
  res_out_t              wr_data;
  logic [FIFO_CNT_W-1:0] fifo_count;
  logic [CREDIT_W-1:0]   pending;

  // credit check against the output queue, input held while a write waits
  assign pending  = CREDIT_W'(fifo_count) + CREDIT_W'(tap.valid && tap.res)
                  + CREDIT_W'(wr_en);
  assign in_stall = (pending >= CREDIT_W'(FIFO_DEPTH)) || cfg_valid;
  assign in_fire  = in_valid && !in_stall;

  // configuration taken once the pipeline is empty
  assign cfg_ready = !tap.valid && !wr_en;
  assign cfg_fire  = cfg_valid && cfg_ready;

  sobvg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_beat   (in_data),
    .cfg_fire  (cfg_fire),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .restart   (restart),
    .issue     (issue)
  );

  sobvg_line_buf u_line_buf (
    .clk   (clk),
    .rst_n (rst_n),
    .issue (issue),
    .tap   (tap)
  );

  sobvg_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (restart),
    .tap     (tap),
    .wr_en   (wr_en),
    .wr_data (wr_data)
  );

  sobvg_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (wr_en),
    .wr_data   (wr_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .count     (fifo_count)
  );

  // queue never holds more than its depth
  assert property (@(posedge clk) disable iff (!rst_n)
    fifo_count <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue overfilled");

  // no write into a full queue unless a beat leaves
  assert property (@(posedge clk) disable iff (!rst_n)
    (fifo_count == FIFO_CNT_W'(FIFO_DEPTH)) |-> (!wr_en || (out_valid && !out_stall)))
    else $error("write into full result queue");

  // a sum stage result comes from a result-carrying read stage
  assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> $past(tap.valid && tap.res))
    else $error("result without a preceding line buffer read");

  // the line buffer read stage only follows a push
  assert property (@(posedge clk) disable iff (!rst_n)
    tap.valid |-> $past(issue.push))
    else $error("line buffer stage without a push");

endmodule

### tb/tb_sobel_vertical_gradient_rgb_core.sv
// tb_sobel_vertical_gradient_rgb_core: self-checking bench for the vertical sobel gradient core
// holds a scoreboard class that predicts each gradient beat and checks the block's output
// depends on sobvg_pkg and sobel_vertical_gradient_rgb_core
`timescale 1ns / 1ps

import sobvg_pkg::*;

// predicts gradient beats from accepted pixel beats and checks what comes out
class vgrad_scoreboard;
  logic [W_REG_W-1:0]   width_reg;
  logic [H_REG_W-1:0]   height_reg;
  pixel_t               above_row [MAX_WIDTH];
  pixel_t               two_above_row [MAX_WIDTH];
  pixel_t               win [3][3];
  logic [W_REG_W-1:0]   in_col;
  logic [ROW_IN_W-1:0]  in_row;
  logic [W_REG_W-1:0]   out_col;
  logic [ROW_OUT_W-1:0] out_row;
  res_out_t             expected_grad [$];
  int                   fail_cnt;

  function new();
    width_reg  = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    // unwritten line entries only ever land in masked taps
    foreach (above_row[i]) begin
      above_row[i]     = '0;
      two_above_row[i] = '0;
    end
    fail_cnt = 0;
    restart_frame();
  endfunction

  function void restart_frame();
    foreach (win[r, c]) win[r][c] = '0;
    in_col  = '0;
    in_row  = '0;
    out_col = '0;
    out_row = '0;
  endfunction

  function int eff_width();
    if (width_reg == '0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return int'(width_reg);
  endfunction

  function int eff_height();
    return (height_reg == '0) ? 1 : int'(height_reg);
  endfunction

  function int pending();
    return expected_grad.size();
  endfunction

  // any write to a real register restarts the frame
  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (idx == REG_WIDTH) begin
      width_reg = data[W_REG_W-1:0];
      restart_frame();
    end else if (idx == REG_HEIGHT) begin
      height_reg = data[H_REG_W-1:0];
      restart_frame();
    end
  endfunction

  // one accepted input beat; returns 0 when the beat is ignored
  function bit take_pixel(pix_in_t beat);
    int       w, h, pos, col;
    int       grad [3];
    bit       draining, left_ok, right_ok, top_ok, bot_ok, last;
    pixel_t   px, top, mid;
    res_out_t res;
    w = eff_width();
    h = eff_height();
    draining = int'(in_row) >= h;
    // flush while pixels are still due: no effect at all
    if (beat.kind == KIND_FLUSH && !draining) return 0;
    px = draining ? '0 : {beat.blue_in, beat.green_in, beat.red_in};

    // line buffers and window shift
    col = int'(in_col);
    if (col >= MAX_WIDTH) col = 0;
    top = two_above_row[col];
    mid = above_row[col];
    two_above_row[col] = mid;
    above_row[col]     = px;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = px;

    pos = int'(in_row) * w + int'(in_col);
    in_col = in_col + 1'b1;
    if (int'(in_col) >= w) begin
      in_col = '0;
      in_row = in_row + 1'b1;
    end
    if (pos < w + 1) return 1;

    // edge masks for the pixel leaving now
    left_ok  = out_col != '0;
    right_ok = int'(out_col) + 1 < w;
    top_ok   = out_row != '0;
    bot_ok   = int'(out_row) + 1 < h;

    // -1,-2,-1 above and +1,+2,+1 below, clamped once
    for (int k = 0; k < 3; k++) begin
      grad[k] = 0;
      if (bot_ok) begin
        grad[k] += 2 * int'(win[2][1][8*k +: 8]);
        if (left_ok)  grad[k] += int'(win[2][0][8*k +: 8]);
        if (right_ok) grad[k] += int'(win[2][2][8*k +: 8]);
      end
      if (top_ok) begin
        grad[k] -= 2 * int'(win[0][1][8*k +: 8]);
        if (left_ok)  grad[k] -= int'(win[0][0][8*k +: 8]);
        if (right_ok) grad[k] -= int'(win[0][2][8*k +: 8]);
      end
      if (grad[k] < 0)   grad[k] = 0;
      if (grad[k] > 255) grad[k] = 255;
    end

    last = (int'(out_col) + 1 >= w) && (int'(out_row) + 1 >= h);
    res.red_out   = 8'(grad[0]);
    res.green_out = 8'(grad[1]);
    res.blue_out  = 8'(grad[2]);
    res.frame_end = last;
    expected_grad.push_back(res);

    out_col = out_col + 1'b1;
    if (int'(out_col) >= w) begin
      out_col = '0;
      out_row = out_row + 1'b1;
    end
    // frame done: positions restart, window keeps its contents
    if (last) begin
      in_col  = '0;
      in_row  = '0;
      out_col = '0;
      out_row = '0;
    end
    return 1;
  endfunction

  // compare one accepted result beat against the oldest prediction
  function void check_result(res_out_t got);
    res_out_t exp_res;
    if (expected_grad.size() == 0) begin
      $error("gradient beat with no prediction waiting: %h", got);
      fail_cnt++;
      return;
    end
    exp_res = expected_grad.pop_front();
    if (got.red_out !== exp_res.red_out) begin
      $error("red_out: expected %0d, got %0d", exp_res.red_out, got.red_out);
      fail_cnt++;
    end
    if (got.green_out !== exp_res.green_out) begin
      $error("green_out: expected %0d, got %0d", exp_res.green_out, got.green_out);
      fail_cnt++;
    end
    if (got.blue_out !== exp_res.blue_out) begin
      $error("blue_out: expected %0d, got %0d", exp_res.blue_out, got.blue_out);
      fail_cnt++;
    end
    if (got.frame_end !== exp_res.frame_end) begin
      $error("frame_end: expected %0d, got %0d", exp_res.frame_end, got.frame_end);
      fail_cnt++;
    end
  endfunction
endclass

module tb_sobel_vertical_gradient_rgb_core;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_BEATS  = 700;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  pix_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  res_out_t              out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  vgrad_scoreboard sb = new();

  int          burst_left = 0;
  int          beats_sent = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;

  sobel_vertical_gradient_rgb_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // watch every handshake at the rising edge, inputs before outputs
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) void'(sb.take_pixel(in_data));
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  // receiver stall pattern, mode changes every so often
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= (stall_left % 8) < 3;
    endcase
  end

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one input beat, sent in bursts with random gaps between them
  task automatic push_beat(input logic kind, input logic [7:0] red, green, blue);
    pix_in_t beat;
    beat.kind     = kind;
    beat.red_in   = red;
    beat.green_in = green;
    beat.blue_in  = blue;
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300)
                                               : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    burst_left--;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // drop valid, wait for every predicted beat, then let the pipeline empty
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // a frame of random pixels, then the drain; abort_at cuts the pixels short
  task automatic run_frame(input int abort_at);
    int w, n;
    w = sb.eff_width();
    n = w * sb.eff_height();
    for (int i = 0; i < n; i++) begin
      if (i == abort_at) return;
      // stray flush while pixels are still due
      if ($urandom_range(0, 24) == 0) push_beat(KIND_FLUSH, rand_chan(), rand_chan(), rand_chan());
      push_beat(KIND_PIXEL, rand_chan(), rand_chan(), rand_chan());
      beats_sent++;
    end
    // drain: a pixel here counts as a flush
    for (int i = 0; i <= w; i++) begin
      push_beat(($urandom_range(0, 3) == 0) ? KIND_PIXEL : KIND_FLUSH,
                rand_chan(), rand_chan(), rand_chan());
      beats_sent++;
    end
  endtask

  // small random frame size, spare width bits set at random
  task automatic random_setup();
    logic [CFG_DATA_W-1:0] wd, hd;
    case ($urandom_range(0, 9))
      0:       wd = '0;
      1:       wd = CFG_DATA_W'($urandom_range(10, 40));
      default: wd = CFG_DATA_W'($urandom_range(1, 9));
    endcase
    wd[CFG_DATA_W-1:W_REG_W] = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 9))
      0:       hd = '0;
      1:       hd = CFG_DATA_W'($urandom_range(7, 12));
      default: hd = CFG_DATA_W'($urandom_range(1, 6));
    endcase
    settle();
    case ($urandom_range(0, 4))
      0: cfg_write(REG_WIDTH, wd);
      1: cfg_write(REG_HEIGHT, hd);
      2: begin
        cfg_write(REG_HEIGHT, hd);
        cfg_write(REG_WIDTH, wd);
      end
      default: begin
        cfg_write(REG_WIDTH, wd);
        cfg_write(REG_HEIGHT, hd);
      end
    endcase
  endtask

  // reset, directed frames, large frames, then random frames
  initial begin
    int n, abort_at;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // flush straight after reset is ignored
    push_beat(KIND_FLUSH, 8'hFF, 8'hFF, 8'hFF);

    // 3x3 frame: bright top row, mixed middle, dark bottom
    settle();
    cfg_write(REG_WIDTH, CFG_DATA_W'(3));
    cfg_write(REG_HEIGHT, CFG_DATA_W'(3));
    push_beat(KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    push_beat(KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    push_beat(KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    push_beat(KIND_PIXEL, 8'hFF, 8'h00, 8'h80);
    push_beat(KIND_FLUSH, 8'h55, 8'hAA, 8'h55);
    push_beat(KIND_PIXEL, 8'h00, 8'hFF, 8'h01);
    push_beat(KIND_PIXEL, 8'h80, 8'h7F, 8'hFE);
    push_beat(KIND_PIXEL, 8'h00, 8'h00, 8'h00);
    push_beat(KIND_PIXEL, 8'h00, 8'h00, 8'h00);
    push_beat(KIND_PIXEL, 8'h00, 8'h00, 8'h00);
    // drain, the first as a pixel whose values are dropped
    push_beat(KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    push_beat(KIND_FLUSH, 8'h00, 8'h00, 8'h00);
    push_beat(KIND_FLUSH, 8'h00, 8'h00, 8'h00);
    push_beat(KIND_FLUSH, 8'h00, 8'h00, 8'h00);
    // flush at the start of the next frame is ignored
    push_beat(KIND_FLUSH, 8'hFF, 8'hFF, 8'hFF);

    // write to an unused index, then zero sizes acting as one
    settle();
    cfg_write(REG_SPARE, CFG_DATA_W'(13'h1ABC));
    cfg_write(REG_WIDTH, '0);
    cfg_write(REG_HEIGHT, '0);
    push_beat(KIND_PIXEL, 8'hFF, 8'h80, 8'h01);
    push_beat(KIND_FLUSH, 8'h00, 8'h00, 8'h00);
    push_beat(KIND_FLUSH, 8'h00, 8'h00, 8'h00);

    // over-range width acts as the full line, cut short past the first wrap
    settle();
    cfg_write(REG_WIDTH, CFG_DATA_W'(2047));
    cfg_write(REG_HEIGHT, CFG_DATA_W'(2));
    run_frame(1030);
    // tall frames up to the largest height, cut short
    settle();
    cfg_write(REG_WIDTH, CFG_DATA_W'(1));
    cfg_write(REG_HEIGHT, CFG_DATA_W'(4096));
    run_frame(150);
    settle();
    cfg_write(REG_HEIGHT, CFG_DATA_W'(13'h1FFF));
    cfg_write(REG_WIDTH, CFG_DATA_W'(2));
    run_frame(100);

    // random sizes, a few frames each, some cut short
    beats_sent = 0;
    while (beats_sent < RANDOM_BEATS) begin
      random_setup();
      n = sb.eff_width() * sb.eff_height();
      for (int f = $urandom_range(1, 3); f > 0; f--) begin
        abort_at = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, n - 1)) : -1;
        run_frame(abort_at);
        if (abort_at >= 0) break;
        if ($urandom_range(0, 7) == 0) push_beat(KIND_FLUSH, rand_chan(), rand_chan(), rand_chan());
      end
    end

    settle();
    if (sb.fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
